// ===== hdl/bmcs_pkg.sv =====
// Shared constants and types for the checkerboard swap unit.
package bmcs_pkg;

	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 1024;
	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int COL_W    = $clog2(MAX_COLS);
	localparam int ADDR_W   = ROW_W + COL_W;
	localparam int ROWS_REG_W = 7;
	localparam int COLS_REG_W = 11;
	localparam int CFG_DATA_W = 11;
	localparam int CFG_IDX_W  = 1;

	localparam int S_TDATA_W = 40;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 8;
	localparam int M_TUSER_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 1'd1;

	localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 7'd64;
	localparam logic [COLS_REG_W-1:0] COLS_RESET = 11'd1024;

	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_WRITE = 2'd0;
	localparam cmd_t CMD_READ  = 2'd1;
	localparam cmd_t CMD_SWAP  = 2'd2;

	typedef logic [1:0] status_t;
	localparam status_t ST_DONE     = 2'd0;
	localparam status_t ST_NO_CHECK = 2'd1;
	localparam status_t ST_BAD      = 2'd2;

endpackage

// ===== hdl/bmcs_bit_ram.sv =====
// Single-port bit memory holding the matrix; the read data is registered.
module bmcs_bit_ram (
	input  logic                      clk,
	input  logic                      en,
	input  logic                      we,
	input  logic [bmcs_pkg::ADDR_W-1:0] addr,
	input  logic                      wdata,
	output logic                      rdata
);
	import bmcs_pkg::*;

	logic mem [(1 << ADDR_W)];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// ===== hdl/binary_matrix_checkerboard_swap_unit.sv =====
// Top level: command sequencer around the matrix bit memory.
//
//  port group   dir  carries
//  s_*          in   s_tuser = cmd; s_tdata = row_a, col_a, row_b, col_b, cell_value
//  m_*          out  m_tuser = status; m_tdata = read_value
//  cfg_*        in   register writes: 0 rows_in_use, 1 cols_in_use
//
// One item at a time; every access goes through the single memory port.
// Write or rejected item: accept, then result. Read: accept, data, result.
// Swap with no checkerboard: four reads plus decision. Swap that flips:
// four reads, four writes, result. The result sits in an output register,
// so a new item is taken while it waits; the next result stalls only if
// that register is still full. No clearing pass: the store is undefined
// until written.
module binary_matrix_checkerboard_swap_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// row_a[5:0], col_a[15:6], row_b[21:16], col_b[31:22], cell_value[32], zero pad
	input  logic [bmcs_pkg::S_TDATA_W-1:0]  s_tdata,
	// cmd[1:0]
	input  logic [bmcs_pkg::S_TUSER_W-1:0]  s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// read_value[0], zero pad
	output logic [bmcs_pkg::M_TDATA_W-1:0]  m_tdata,
	// status[1:0]
	output logic [bmcs_pkg::M_TUSER_W-1:0]  m_tuser,
	input  logic                            cfg_we,
	input  logic [bmcs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bmcs_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bmcs_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_RDATA = 3'd1;
	localparam logic [2:0] S_SWRD  = 3'd2;
	localparam logic [2:0] S_SWCHK = 3'd3;
	localparam logic [2:0] S_SWWR  = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0]            state_q;
	logic [1:0]            step_q;
	logic [2:0]            vals_q;
	logic                  res_rd_q;
	status_t               res_st_q;
	logic                  m_tvalid_q;
	logic                  m_rd_q;
	status_t               m_st_q;
	logic [ROWS_REG_W-1:0] rows_q;
	logic [COLS_REG_W-1:0] cols_q;
	logic [ROW_W-1:0]      ra_q, rb_q;
	logic [COL_W-1:0]      ca_q, cb_q;

	cmd_t             in_cmd;
	logic [ROW_W-1:0] in_row_a, in_row_b;
	logic [COL_W-1:0] in_col_a, in_col_b;
	logic             in_cell;
	logic             accept;
	logic             a_ok, swap_ok, is_checker, out_free;

	logic             ram_en, ram_we, ram_wdata, ram_rdata;
	logic [ROW_W-1:0] ram_row;
	logic [COL_W-1:0] ram_col;

	assign in_cmd   = s_tuser;
	assign in_row_a = s_tdata[ROW_W-1:0];
	assign in_col_a = s_tdata[ROW_W +: COL_W];
	assign in_row_b = s_tdata[ROW_W+COL_W +: ROW_W];
	assign in_col_b = s_tdata[2*ROW_W+COL_W +: COL_W];
	assign in_cell  = s_tdata[2*ROW_W+2*COL_W];

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// Indices are narrower than the maxima, so only the registers limit them.
	assign a_ok = ({1'b0, in_row_a} < rows_q) && ({1'b0, in_col_a} < cols_q);
	assign swap_ok = a_ok && ({1'b0, in_row_b} < rows_q) && ({1'b0, in_col_b} < cols_q)
		&& (in_row_a != in_row_b) && (in_col_a != in_col_b);

	// vals_q holds v11, v12, v21; v22 arrives on the port in S_SWCHK
	assign is_checker = (vals_q[0] == ram_rdata) && (vals_q[1] == vals_q[2])
		&& (vals_q[0] != vals_q[1]);

	// corner order: (ra,ca) (ra,cb) (rb,ca) (rb,cb)
	always_comb begin
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_row   = step_q[1] ? rb_q : ra_q;
		ram_col   = step_q[0] ? cb_q : ca_q;
		ram_wdata = ~vals_q[0] ^ (step_q[1] ^ step_q[0]);
		case (state_q)
			S_IDLE: begin
				ram_row   = in_row_a;
				ram_col   = in_col_a;
				ram_wdata = in_cell;
				if (accept) begin
					case (in_cmd)
						CMD_WRITE: begin
							ram_en = a_ok;
							ram_we = a_ok;
						end
						CMD_READ: ram_en = a_ok;
						CMD_SWAP: ram_en = swap_ok;
						default: ram_en = 1'b0;
					endcase
				end
			end
			S_SWRD: ram_en = 1'b1;
			S_SWCHK: begin
				ram_row   = ra_q;
				ram_col   = ca_q;
				ram_wdata = ~vals_q[0];
				ram_en    = is_checker;
				ram_we    = is_checker;
			end
			S_SWWR: begin
				ram_en = 1'b1;
				ram_we = 1'b1;
			end
			default: ram_en = 1'b0;
		endcase
	end

	bmcs_bit_ram u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  ({ram_row, ram_col}),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_RESET;
			cols_q <= COLS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROWS_IN_USE: rows_q <= cfg_data[ROWS_REG_W-1:0];
				REG_COLS_IN_USE: cols_q <= cfg_data[COLS_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			step_q     <= 2'd0;
			m_tvalid_q <= 1'b0;
		end else begin
			// S_DONE reloads the output register itself
			if (m_tvalid_q && m_tready && state_q != S_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						step_q <= 2'd1;
						if (in_cmd == CMD_READ && a_ok) begin
							state_q <= S_RDATA;
						end else if (in_cmd == CMD_SWAP && swap_ok) begin
							state_q <= S_SWRD;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_RDATA: state_q <= S_DONE;
				S_SWRD: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) begin
						state_q <= S_SWCHK;
					end
				end
				S_SWCHK: begin
					step_q  <= 2'd1;
					state_q <= is_checker ? S_SWWR : S_DONE;
				end
				S_SWWR: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					ra_q     <= in_row_a;
					ca_q     <= in_col_a;
					rb_q     <= in_row_b;
					cb_q     <= in_col_b;
					res_rd_q <= 1'b0;
					case (in_cmd)
						CMD_WRITE: res_st_q <= a_ok ? ST_DONE : ST_BAD;
						CMD_READ:  res_st_q <= a_ok ? ST_DONE : ST_BAD;
						default:   res_st_q <= ST_BAD;
					endcase
				end
			end
			S_RDATA: res_rd_q <= ram_rdata;
			S_SWRD: vals_q[step_q - 2'd1] <= ram_rdata;
			S_SWCHK: res_st_q <= is_checker ? ST_DONE : ST_NO_CHECK;
			S_DONE: begin
				if (out_free) begin
					m_rd_q <= res_rd_q;
					m_st_q <= res_st_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(M_TDATA_W-1){1'b0}}, m_rd_q};
	assign m_tuser  = m_st_q;

endmodule

// ===== tb/tb_binary_matrix_checkerboard_swap_unit.sv =====
// Self-checking testbench for the checkerboard swap unit: directed corners, then random phases.
module tb_binary_matrix_checkerboard_swap_unit;
	import bmcs_pkg::*;

	localparam int CLK_HALF = 6;
	localparam int RESET_CYCLES = 7;
	localparam int MAX_GAP = 16;
	// long output hold to back the block up into its input
	localparam int HOLD_CYCLES = 300;
	// longest quiet spell in a good run is the hold plus one slow swap; allow ~6x
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 20;
	localparam int PRINT_CAP = 100;
	localparam cmd_t CMD_UNUSED = 2'd3;

	typedef struct {
		cmd_t                 cmd;
		logic [ROW_W-1:0]     row_a;
		logic [COL_W-1:0]     col_a;
		logic [ROW_W-1:0]     row_b;
		logic [COL_W-1:0]     col_b;
		logic                 cell_value;
	} op_t;

	typedef struct {
		cmd_t    cmd;
		logic    read_value;
		status_t status;
	} reply_t;

	class matrix_scoreboard;
		bit      mat_bits [MAX_ROWS*MAX_COLS];
		bit      mat_known [MAX_ROWS*MAX_COLS];
		int      rows_reg;
		int      cols_reg;
		reply_t  awaited_replies [$];
		int      errors;

		function new();
			rows_reg = int'(ROWS_RESET);
			cols_reg = int'(COLS_RESET);
			errors = 0;
		endfunction

		function void set_sizes(int rows_val, int cols_val);
			rows_reg = rows_val & 'h7F;
			cols_reg = cols_val & 'h7FF;
		endfunction

		function int pending();
			return awaited_replies.size();
		endfunction

		function bit row_ok(int r);
			return r < rows_reg && r < MAX_ROWS;
		endfunction

		function bit col_ok(int c);
			return c < cols_reg && c < MAX_COLS;
		endfunction

		function int addr(int r, int c);
			return r * MAX_COLS + c;
		endfunction

		function bit swap_ok(op_t op);
			return row_ok(op.row_a) && row_ok(op.row_b) && col_ok(op.col_a) &&
				col_ok(op.col_b) && op.row_a != op.row_b && op.col_a != op.col_b;
		endfunction

		// true when the item would look at a cell that was never written
		function bit reads_unwritten(op_t op);
			if (op.cmd == CMD_READ && row_ok(op.row_a) && col_ok(op.col_a))
				return !mat_known[addr(op.row_a, op.col_a)];
			if (op.cmd == CMD_SWAP && swap_ok(op))
				return !(mat_known[addr(op.row_a, op.col_a)] &&
					mat_known[addr(op.row_a, op.col_b)] &&
					mat_known[addr(op.row_b, op.col_a)] &&
					mat_known[addr(op.row_b, op.col_b)]);
			return 1'b0;
		endfunction

		function void note_command(op_t op);
			reply_t want;
			int a11, a12, a21, a22;
			want.cmd = op.cmd;
			want.read_value = 1'b0;
			want.status = ST_BAD;
			case (op.cmd)
				CMD_WRITE: begin
					if (row_ok(op.row_a) && col_ok(op.col_a)) begin
						a11 = addr(op.row_a, op.col_a);
						mat_bits[a11] = op.cell_value;
						mat_known[a11] = 1'b1;
						want.status = ST_DONE;
					end
				end
				CMD_READ: begin
					if (row_ok(op.row_a) && col_ok(op.col_a)) begin
						want.read_value = mat_bits[addr(op.row_a, op.col_a)];
						want.status = ST_DONE;
					end
				end
				CMD_SWAP: begin
					if (swap_ok(op)) begin
						a11 = addr(op.row_a, op.col_a);
						a12 = addr(op.row_a, op.col_b);
						a21 = addr(op.row_b, op.col_a);
						a22 = addr(op.row_b, op.col_b);
						if (mat_bits[a11] == mat_bits[a22] && mat_bits[a12] == mat_bits[a21] &&
							mat_bits[a11] != mat_bits[a12]) begin
							mat_bits[a11] = !mat_bits[a11];
							mat_bits[a12] = !mat_bits[a12];
							mat_bits[a21] = !mat_bits[a21];
							mat_bits[a22] = !mat_bits[a22];
							want.status = ST_DONE;
						end else begin
							want.status = ST_NO_CHECK;
						end
					end
				end
				default: ;
			endcase
			awaited_replies.push_back(want);
		endfunction

		task report(string msg);
			if (errors < PRINT_CAP)
				$display("ERROR @%0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_reply(logic rv, status_t st);
			reply_t want;
			if (awaited_replies.size() == 0) begin
				report($sformatf("reply with nothing awaited: read_value=%b status=%0d", rv, st));
				return;
			end
			want = awaited_replies.pop_front();
			if (rv !== want.read_value)
				report($sformatf("cmd %0d read_value %b, expected %b", want.cmd, rv,
					want.read_value));
			if (st !== want.status)
				report($sformatf("cmd %0d status %0d, expected %0d", want.cmd, st,
					want.status));
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata = '0;
	logic [S_TUSER_W-1:0]  s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic [M_TUSER_W-1:0]  m_tuser;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	matrix_scoreboard board = new();
	bit send_eager = 1'b0;
	bit reply_eager = 1'b0;
	bit hold_request = 1'b0;
	int idle_cycles = 0;

	binary_matrix_checkerboard_swap_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_HALF) clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// runs of back-to-back items alternate with runs of random gaps
	function automatic int draw_gap(inout bit eager);
		if ($urandom_range(0, 23) == 0)
			eager = !eager;
		return eager ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	function automatic op_t make_op(cmd_t c, int ra, int ca, int rb, int cb, int v);
		op_t op;
		op.cmd = c;
		op.row_a = ROW_W'(ra);
		op.col_a = COL_W'(ca);
		op.row_b = ROW_W'(rb);
		op.col_b = COL_W'(cb);
		op.cell_value = v[0];
		return op;
	endfunction

	// either anywhere in the field's range or at the limit in use or just below it
	function automatic int pick_index(int lim, int top);
		int v;
		if ($urandom_range(0, 1))
			return $urandom_range(0, top);
		v = lim - $urandom_range(0, 1);
		if (v < 0)
			v = 0;
		if (v > top)
			v = top;
		return v;
	endfunction

	task automatic send_command(input op_t op);
		int gap;
		gap = draw_gap(send_eager);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		// never look at a cell before it holds a value
		if (board.reads_unwritten(op))
			op.cmd = CMD_WRITE;
		s_tvalid <= 1'b1;
		s_tuser <= op.cmd;
		s_tdata <= {7'd0, op.cell_value, op.col_b, op.row_b, op.col_a, op.row_a};
		do @(posedge clk); while (s_tready !== 1'b1);
		board.note_command(op);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
	endtask

	task automatic run_phase(input int rows_val, input int cols_val, input int n_items,
		input bit program_sizes);
		int eff_r, eff_c, kind, v, count;
		int ra, rb, ca, cb;
		int hot_r [$];
		int hot_c [$];
		if (program_sizes) begin
			drain();
			cfg_we <= 1'b1;
			cfg_index <= REG_ROWS_IN_USE;
			cfg_data <= CFG_DATA_W'(rows_val);
			@(posedge clk);
			cfg_index <= REG_COLS_IN_USE;
			cfg_data <= CFG_DATA_W'(cols_val);
			@(posedge clk);
			cfg_we <= 1'b0;
			board.set_sizes(rows_val, cols_val);
		end
		eff_r = rows_val > MAX_ROWS ? MAX_ROWS : rows_val;
		eff_c = cols_val > MAX_COLS ? MAX_COLS : cols_val;
		// small working window: top edge, zero and two random indices
		if (eff_r > 0) begin
			hot_r.push_back(eff_r - 1);
			if (eff_r > 1) begin
				hot_r.push_back(0);
				hot_r.push_back($urandom_range(0, eff_r - 1));
				hot_r.push_back($urandom_range(0, eff_r - 1));
			end
		end
		if (eff_c > 0) begin
			hot_c.push_back(eff_c - 1);
			if (eff_c > 1) begin
				hot_c.push_back(0);
				hot_c.push_back($urandom_range(0, eff_c - 1));
				hot_c.push_back($urandom_range(0, eff_c - 1));
			end
		end
		count = 0;
		foreach (hot_r[i])
			foreach (hot_c[j]) begin
				send_command(make_op(CMD_WRITE, hot_r[i], hot_c[j], 0, 0,
					$urandom_range(0, 1)));
				count++;
			end
		while (count < n_items) begin
			kind = (hot_r.size() == 0 || hot_c.size() == 0) ? 99 : $urandom_range(0, 99);
			ra = hot_r.size() ? hot_r[$urandom_range(0, hot_r.size() - 1)] : 0;
			rb = hot_r.size() ? hot_r[$urandom_range(0, hot_r.size() - 1)] : 0;
			ca = hot_c.size() ? hot_c[$urandom_range(0, hot_c.size() - 1)] : 0;
			cb = hot_c.size() ? hot_c[$urandom_range(0, hot_c.size() - 1)] : 0;
			v = $urandom_range(0, 1);
			if (kind < 20) begin
				send_command(make_op(CMD_WRITE, ra, ca, rb, cb, v));
				count++;
			end else if (kind < 35) begin
				send_command(make_op(CMD_READ, ra, ca, rb, cb, v));
				count++;
			end else if (kind < 75) begin
				send_command(make_op(CMD_SWAP, ra, ca, rb, cb, v));
				count++;
			end else if (kind < 88) begin
				// lay down a checkerboard, swap it, read back one corner
				send_command(make_op(CMD_WRITE, ra, ca, 0, 0, v));
				send_command(make_op(CMD_WRITE, ra, cb, 0, 0, !v));
				send_command(make_op(CMD_WRITE, rb, ca, 0, 0, !v));
				send_command(make_op(CMD_WRITE, rb, cb, 0, 0, v));
				send_command(make_op(CMD_SWAP, ra, ca, rb, cb, $urandom_range(0, 1)));
				send_command(make_op(CMD_READ, rb, cb, ra, ca, $urandom_range(0, 1)));
				count += 6;
			end else begin
				send_command(make_op(cmd_t'($urandom_range(0, 3)),
					pick_index(eff_r, MAX_ROWS - 1), pick_index(eff_c, MAX_COLS - 1),
					pick_index(eff_r, MAX_ROWS - 1), pick_index(eff_c, MAX_COLS - 1), v));
				count++;
			end
		end
	endtask

	initial begin : reply_side
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			gap = draw_gap(reply_eager);
			if (hold_request) begin
				hold_request = 1'b0;
				gap = HOLD_CYCLES;
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			board.check_reply(m_tdata[0], status_t'(m_tuser));
		end
	end

	initial begin : stimulus
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset sizes; corners of the full matrix
		send_command(make_op(CMD_WRITE, 0, 0, 0, 0, 1));
		send_command(make_op(CMD_WRITE, 0, 1023, 0, 0, 0));
		send_command(make_op(CMD_WRITE, 63, 0, 0, 0, 0));
		send_command(make_op(CMD_WRITE, 63, 1023, 0, 0, 1));
		// 10/01 pattern flips
		send_command(make_op(CMD_SWAP, 0, 0, 63, 1023, 0));
		send_command(make_op(CMD_READ, 0, 0, 0, 0, 0));
		send_command(make_op(CMD_READ, 63, 1023, 0, 0, 0));
		send_command(make_op(CMD_READ, 0, 1023, 0, 0, 0));
		send_command(make_op(CMD_READ, 63, 0, 0, 0, 0));
		// 01/10 pattern flips back
		send_command(make_op(CMD_SWAP, 63, 1023, 0, 0, 0));
		// break the pattern: no checkerboard
		send_command(make_op(CMD_WRITE, 0, 0, 0, 0, 0));
		send_command(make_op(CMD_SWAP, 0, 0, 63, 1023, 0));
		// repeated row, repeated column, unused command
		send_command(make_op(CMD_SWAP, 0, 0, 0, 1023, 0));
		send_command(make_op(CMD_SWAP, 0, 5, 63, 5, 0));
		send_command(make_op(CMD_UNUSED, 63, 1023, 63, 1023, 1));
		// cell_value set where it is not used; replies must not depend on it
		send_command(make_op(CMD_READ, 63, 1023, 63, 1023, 1));
		send_command(make_op(CMD_SWAP, 63, 1023, 0, 0, 1));
		send_command(make_op(CMD_READ, 0, 1023, 0, 0, 1));

		hold_request = 1'b1;
		run_phase(64, 1024, 130, 1'b0);
		run_phase(2, 2, 60, 1'b1);
		run_phase(127, 2047, 90, 1'b1);
		run_phase(1, 5, 40, 1'b1);
		run_phase(0, 0, 30, 1'b1);
		run_phase(13, 37, 80, 1'b1);
		run_phase(64, 1, 30, 1'b1);
		run_phase(64, 1024, 100, 1'b1);
		run_phase($urandom_range(2, MAX_ROWS), $urandom_range(2, MAX_COLS), 90, 1'b1);

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/bmcs_pkg.sv
hdl/bmcs_bit_ram.sv
hdl/binary_matrix_checkerboard_swap_unit.sv
tb/tb_binary_matrix_checkerboard_swap_unit.sv
